FILE: sv/biq_pkg.sv
// Package for the biquad IIR filter unit: register indexes, sequencer states
// and the control word passed from the sequencer to the shared multiply-add unit.
// No dependencies.
package biq_pkg;

	localparam int CFG_IDX_BITS = 3;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_COEF_B0       = 3'd0,
		REG_COEF_B1       = 3'd1,
		REG_COEF_B2       = 3'd2,
		REG_COEF_A1       = 3'd3,
		REG_COEF_A2       = 3'd4,
		REG_INIT_FIRST    = 3'd5,
		REG_INIT_SECOND   = 3'd6
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_B0,
		ST_ADD_D1,
		ST_ROUND,
		ST_MUL_A1,
		ST_SUB_A1,
		ST_ADD_D2,
		ST_LOAD_B2,
		ST_FINISH
	} state_t;

	typedef enum logic [2:0] {
		MC_B0,
		MC_B1,
		MC_B2,
		MC_A1,
		MC_A2
	} mul_coef_t;

	typedef enum logic [1:0] {
		AA_ZERO,
		AA_ACC,
		AA_D1
	} add_a_t;

	typedef enum logic [1:0] {
		AB_PROD,
		AB_NEG_PROD,
		AB_D2
	} add_b_t;

	typedef struct packed {
		mul_coef_t mul_coef;
		logic      mul_by_y;
		logic      prod_we;
		add_a_t    add_a;
		add_b_t    add_b;
		logic      acc_we;
		logic      d1_we;
		logic      d2_we;
		logic      y_we;
		logic      out_load;
	} ctrl_t;

endpackage

FILE: sv/biq_ifs.sv
// Request channel interfaces of the biquad IIR filter unit: input samples and
// filtered results, each with valid, ready and payload. No dependencies.
interface biq_in_if #(
	parameter int SAMPLE_BITS = 16
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;
	logic                          first_sample;

	modport source (output valid, sample_in, first_sample, input ready);
	modport sink (input valid, sample_in, first_sample, output ready);
endinterface

interface biq_out_if #(
	parameter int SAMPLE_BITS = 16
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic                          clipped;

	modport source (output valid, sample_out, clipped, input ready);
	modport sink (input valid, sample_out, clipped, output ready);
endinterface

FILE: sv/biq_sat.sv
// Signed saturation of a value of any width to a narrower or wider signed width,
// with a flag that marks a clamped value. No dependencies.
module biq_sat #(
	parameter int IN_W  = 41,
	parameter int OUT_W = 40
) (
	input  logic signed [IN_W-1:0]  din,
	output logic signed [OUT_W-1:0] dout,
	output logic                    hit
);

	localparam int EW = ((IN_W > OUT_W) ? IN_W : OUT_W) + 1;
	localparam logic signed [EW-1:0] HI = {{(EW-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
	localparam logic signed [EW-1:0] LO = ~HI;

	logic signed [EW-1:0] ext;

	assign ext = EW'(din);

	always_comb begin
		priority if (ext > HI) begin
			dout = HI[OUT_W-1:0];
			hit  = 1'b1;
		end else if (ext < LO) begin
			dout = LO[OUT_W-1:0];
			hit  = 1'b1;
		end else begin
			dout = ext[OUT_W-1:0];
			hit  = 1'b0;
		end
	end

endmodule

FILE: sv/biq_mac.sv
// Shared arithmetic unit of the biquad filter: one coefficient-by-sample multiplier
// with a registered, saturated product, and one saturating adder.
// Depends on biq_pkg and biq_sat.
module biq_mac #(
	parameter int SAMPLE_BITS = 16,
	parameter int COEF_BITS   = 18,
	parameter int STATE_BITS  = 40
) (
	input  logic                          clk,
	input  biq_pkg::ctrl_t                ctrl,
	input  logic signed [COEF_BITS-1:0]   coef_b0,
	input  logic signed [COEF_BITS-1:0]   coef_b1,
	input  logic signed [COEF_BITS-1:0]   coef_b2,
	input  logic signed [COEF_BITS-1:0]   coef_a1,
	input  logic signed [COEF_BITS-1:0]   coef_a2,
	input  logic signed [SAMPLE_BITS-1:0] x,
	input  logic signed [SAMPLE_BITS-1:0] y,
	input  logic signed [STATE_BITS-1:0]  acc,
	input  logic signed [STATE_BITS-1:0]  d1,
	input  logic signed [STATE_BITS-1:0]  d2,
	output logic signed [STATE_BITS-1:0]  sum
);

	localparam int P = COEF_BITS + SAMPLE_BITS;

	logic signed [COEF_BITS-1:0]   coef_sel;
	logic signed [SAMPLE_BITS-1:0] opnd;
	logic signed [P-1:0]           product;
	logic signed [STATE_BITS-1:0]  prod_sat;
	logic signed [STATE_BITS-1:0]  prod_q;
	logic signed [STATE_BITS:0]    prod_ext;
	logic signed [STATE_BITS-1:0]  a_op;
	logic signed [STATE_BITS:0]    b_op;
	logic signed [STATE_BITS+1:0]  sum_raw;

	always_comb begin
		unique case (ctrl.mul_coef)
			biq_pkg::MC_B0: coef_sel = coef_b0;
			biq_pkg::MC_B1: coef_sel = coef_b1;
			biq_pkg::MC_B2: coef_sel = coef_b2;
			biq_pkg::MC_A1: coef_sel = coef_a1;
			biq_pkg::MC_A2: coef_sel = coef_a2;
			default:        coef_sel = '0;
		endcase
	end

	assign opnd    = ctrl.mul_by_y ? y : x;
	assign product = P'(coef_sel) * P'(opnd);

	biq_sat #(.IN_W(P), .OUT_W(STATE_BITS)) u_prod_sat (
		.din  (product),
		.dout (prod_sat),
		.hit  ()
	);

	always_ff @(posedge clk) begin
		if (ctrl.prod_we) begin
			prod_q <= prod_sat;
		end
	end

	assign prod_ext = (STATE_BITS+1)'(prod_q);

	always_comb begin
		unique case (ctrl.add_a)
			biq_pkg::AA_ZERO: a_op = '0;
			biq_pkg::AA_ACC:  a_op = acc;
			biq_pkg::AA_D1:   a_op = d1;
			default:          a_op = '0;
		endcase
		unique case (ctrl.add_b)
			biq_pkg::AB_PROD:     b_op = prod_ext;
			biq_pkg::AB_NEG_PROD: b_op = -prod_ext;
			biq_pkg::AB_D2:       b_op = (STATE_BITS+1)'(d2);
			default:              b_op = '0;
		endcase
	end

	assign sum_raw = (STATE_BITS+2)'(a_op) + (STATE_BITS+2)'(b_op);

	biq_sat #(.IN_W(STATE_BITS+2), .OUT_W(STATE_BITS)) u_sum_sat (
		.din  (sum_raw),
		.dout (sum),
		.hit  ()
	);

endmodule

FILE: sv/biq_ctrl.sv
// Sequencer of the biquad filter: steps one sample through the shared
// multiply-add unit and issues the control word for each step. Depends on biq_pkg.
module biq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           out_free,
	output logic           idle,
	output biq_pkg::ctrl_t ctrl
);

	biq_pkg::state_t state_q;
	biq_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= biq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		ctrl          = '0;
		ctrl.mul_coef = biq_pkg::MC_B0;
		ctrl.add_a    = biq_pkg::AA_ZERO;
		ctrl.add_b    = biq_pkg::AB_PROD;
		state_d       = state_q;
		idle          = 1'b0;
		unique case (state_q)
			biq_pkg::ST_IDLE: begin
				idle = 1'b1;
				if (start) begin
					state_d = biq_pkg::ST_MUL_B0;
				end
			end
			biq_pkg::ST_MUL_B0: begin
				ctrl.mul_coef = biq_pkg::MC_B0;
				ctrl.prod_we  = 1'b1;
				state_d       = biq_pkg::ST_ADD_D1;
			end
			biq_pkg::ST_ADD_D1: begin
				ctrl.add_a    = biq_pkg::AA_D1;
				ctrl.add_b    = biq_pkg::AB_PROD;
				ctrl.acc_we   = 1'b1;
				ctrl.mul_coef = biq_pkg::MC_B1;
				ctrl.prod_we  = 1'b1;
				state_d       = biq_pkg::ST_ROUND;
			end
			biq_pkg::ST_ROUND: begin
				ctrl.y_we   = 1'b1;
				ctrl.add_a  = biq_pkg::AA_ZERO;
				ctrl.add_b  = biq_pkg::AB_PROD;
				ctrl.acc_we = 1'b1;
				state_d     = biq_pkg::ST_MUL_A1;
			end
			biq_pkg::ST_MUL_A1: begin
				ctrl.mul_coef = biq_pkg::MC_A1;
				ctrl.mul_by_y = 1'b1;
				ctrl.prod_we  = 1'b1;
				state_d       = biq_pkg::ST_SUB_A1;
			end
			biq_pkg::ST_SUB_A1: begin
				ctrl.add_a    = biq_pkg::AA_ACC;
				ctrl.add_b    = biq_pkg::AB_NEG_PROD;
				ctrl.acc_we   = 1'b1;
				ctrl.mul_coef = biq_pkg::MC_B2;
				ctrl.prod_we  = 1'b1;
				state_d       = biq_pkg::ST_ADD_D2;
			end
			biq_pkg::ST_ADD_D2: begin
				ctrl.add_a = biq_pkg::AA_ACC;
				ctrl.add_b = biq_pkg::AB_D2;
				ctrl.d1_we = 1'b1;
				state_d    = biq_pkg::ST_LOAD_B2;
			end
			biq_pkg::ST_LOAD_B2: begin
				ctrl.add_a    = biq_pkg::AA_ZERO;
				ctrl.add_b    = biq_pkg::AB_PROD;
				ctrl.acc_we   = 1'b1;
				ctrl.mul_coef = biq_pkg::MC_A2;
				ctrl.mul_by_y = 1'b1;
				ctrl.prod_we  = 1'b1;
				state_d       = biq_pkg::ST_FINISH;
			end
			biq_pkg::ST_FINISH: begin
				// The second state and the result are committed together, once.
				ctrl.add_a    = biq_pkg::AA_ACC;
				ctrl.add_b    = biq_pkg::AB_NEG_PROD;
				ctrl.d2_we    = out_free;
				ctrl.out_load = out_free;
				if (out_free) begin
					state_d = biq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = biq_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

FILE: sv/biquad_iir_filter_unit.sv
// Biquad IIR section in transposed direct form II with Q3.14 coefficients and
// wide saturating delay states; the output is rounded half up, saturated to the
// sample width and flagged when clipped. One multiplier and one saturating adder
// are shared under a sequencer; an accepted sample passes through eight sequencer
// steps before the next is accepted, and the last step stalls while the previous
// result still waits in the output register. A sample with first_sample set loads
// both delay states from the initial-value registers before it is filtered. The
// user must write registers only while no sample is in progress; the block does
// not enforce this. Depends on biq_pkg, biq_ifs, biq_sat, biq_mac, biq_ctrl.
module biquad_iir_filter_unit #(
	parameter int SAMPLE_BITS = 16,
	parameter int COEF_BITS   = 18,
	parameter int STATE_BITS  = 40,
	localparam int CFG_W = (COEF_BITS > SAMPLE_BITS + 1) ? COEF_BITS : SAMPLE_BITS + 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [biq_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_W-1:0]                  cfg_wdata,
	biq_in_if.sink                            sample_chan,
	biq_out_if.source                         result_chan
);

	localparam int COEF_FRAC = COEF_BITS - 4;
	localparam int INIT_BITS = SAMPLE_BITS + 1;
	localparam int IW        = INIT_BITS + COEF_FRAC;
	localparam int QW        = STATE_BITS + 1 - COEF_FRAC;
	localparam logic signed [STATE_BITS:0] HALF = (STATE_BITS+1)'(1) <<< (COEF_FRAC - 1);
	localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SMIN = ~SMAX;

	logic signed [COEF_BITS-1:0]   coef_b0_q;
	logic signed [COEF_BITS-1:0]   coef_b1_q;
	logic signed [COEF_BITS-1:0]   coef_b2_q;
	logic signed [COEF_BITS-1:0]   coef_a1_q;
	logic signed [COEF_BITS-1:0]   coef_a2_q;
	logic signed [INIT_BITS-1:0]   init_first_q;
	logic signed [INIT_BITS-1:0]   init_second_q;

	logic signed [SAMPLE_BITS-1:0] x_q;
	logic signed [SAMPLE_BITS-1:0] y_q;
	logic                          clip_q;
	logic signed [STATE_BITS-1:0]  acc_q;
	logic signed [STATE_BITS-1:0]  d1_q;
	logic signed [STATE_BITS-1:0]  d2_q;
	logic signed [STATE_BITS-1:0]  sum;

	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] sample_out_q;
	logic                          clipped_q;

	logic                          idle;
	logic                          in_accept;
	logic                          out_free;
	biq_pkg::ctrl_t                ctrl;

	logic signed [IW-1:0]          init1_ext;
	logic signed [IW-1:0]          init2_ext;
	logic signed [STATE_BITS-1:0]  init1_state;
	logic signed [STATE_BITS-1:0]  init2_state;
	logic signed [STATE_BITS:0]    rnd_sum;
	logic signed [QW-1:0]          rnd_q;
	logic signed [SAMPLE_BITS-1:0] y_next;
	logic                          clip_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_b0_q     <= COEF_BITS'(1) << COEF_FRAC;
			coef_b1_q     <= '0;
			coef_b2_q     <= '0;
			coef_a1_q     <= '0;
			coef_a2_q     <= '0;
			init_first_q  <= '0;
			init_second_q <= '0;
		end else if (cfg_we) begin
			unique case (biq_pkg::reg_idx_t'(cfg_index))
				biq_pkg::REG_COEF_B0:     coef_b0_q     <= cfg_wdata[COEF_BITS-1:0];
				biq_pkg::REG_COEF_B1:     coef_b1_q     <= cfg_wdata[COEF_BITS-1:0];
				biq_pkg::REG_COEF_B2:     coef_b2_q     <= cfg_wdata[COEF_BITS-1:0];
				biq_pkg::REG_COEF_A1:     coef_a1_q     <= cfg_wdata[COEF_BITS-1:0];
				biq_pkg::REG_COEF_A2:     coef_a2_q     <= cfg_wdata[COEF_BITS-1:0];
				biq_pkg::REG_INIT_FIRST:  init_first_q  <= cfg_wdata[INIT_BITS-1:0];
				biq_pkg::REG_INIT_SECOND: init_second_q <= cfg_wdata[INIT_BITS-1:0];
				default: ;
			endcase
		end
	end

	biq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_accept),
		.out_free (out_free),
		.idle     (idle),
		.ctrl     (ctrl)
	);

	biq_mac #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.COEF_BITS   (COEF_BITS),
		.STATE_BITS  (STATE_BITS)
	) u_mac (
		.clk     (clk),
		.ctrl    (ctrl),
		.coef_b0 (coef_b0_q),
		.coef_b1 (coef_b1_q),
		.coef_b2 (coef_b2_q),
		.coef_a1 (coef_a1_q),
		.coef_a2 (coef_a2_q),
		.x       (x_q),
		.y       (y_q),
		.acc     (acc_q),
		.d1      (d1_q),
		.d2      (d2_q),
		.sum     (sum)
	);

	assign sample_chan.ready = idle;
	assign in_accept         = sample_chan.valid && idle;
	assign out_free          = !out_valid_q || result_chan.ready;

	assign init1_ext = IW'(init_first_q) <<< COEF_FRAC;
	assign init2_ext = IW'(init_second_q) <<< COEF_FRAC;

	biq_sat #(.IN_W(IW), .OUT_W(STATE_BITS)) u_init1_sat (
		.din  (init1_ext),
		.dout (init1_state),
		.hit  ()
	);

	biq_sat #(.IN_W(IW), .OUT_W(STATE_BITS)) u_init2_sat (
		.din  (init2_ext),
		.dout (init2_state),
		.hit  ()
	);

	assign rnd_sum = (STATE_BITS+1)'(acc_q) + HALF;
	assign rnd_q   = rnd_sum[STATE_BITS:COEF_FRAC];

	biq_sat #(.IN_W(QW), .OUT_W(SAMPLE_BITS)) u_out_sat (
		.din  (rnd_q),
		.dout (y_next),
		.hit  (clip_next)
	);

	always_ff @(posedge clk) begin
		if (in_accept) begin
			x_q <= sample_chan.sample_in;
		end
		if (ctrl.acc_we) begin
			acc_q <= sum;
		end
		if (ctrl.y_we) begin
			y_q    <= y_next;
			clip_q <= clip_next;
		end
		if (ctrl.out_load) begin
			sample_out_q <= y_q;
			clipped_q    <= clip_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d1_q <= '0;
			d2_q <= '0;
		end else begin
			if (in_accept && sample_chan.first_sample) begin
				d1_q <= init1_state;
				d2_q <= init2_state;
			end else begin
				if (ctrl.d1_we) begin
					d1_q <= sum;
				end
				if (ctrl.d2_we) begin
					d2_q <= sum;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (result_chan.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result_chan.valid      = out_valid_q;
	assign result_chan.sample_out = sample_out_q;
	assign result_chan.clipped    = clipped_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> !sample_chan.ready)
		else $error("Sample accepted while the previous one is still in progress.");

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.out_load |-> (!out_valid_q || result_chan.ready))
		else $error("Result loaded over one that was not yet taken.");

	a_clip_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(result_chan.valid && result_chan.clipped) |->
		(result_chan.sample_out == SMAX || result_chan.sample_out == SMIN))
		else $error("Clipped flag set on a result that is not at a limit.");

	a_state_commit_once: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.d2_we |=> !ctrl.d2_we)
		else $error("Second delay state committed twice for one sample.");

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for biquad_iir_filter_unit: drives sample requests,
// predicts each filtered result and compares it. Depends on biq_pkg, biq_ifs and the RTL.
module testbench;

	localparam int SAMPLE_W = 16;
	localparam int COEF_W   = 18;
	localparam int INIT_W   = 17;
	localparam int CFG_W    = 18;
	localparam int FRAC     = COEF_W - 4;
	localparam logic [biq_pkg::CFG_IDX_BITS-1:0] CFG_IDX_UNUSED = 3'd7;
	localparam longint STATE_MAX = (64'sd1 <<< 39) - 1;
	localparam longint STATE_MIN = -STATE_MAX - 1;

	typedef struct {
		logic signed [SAMPLE_W-1:0] sample_out;
		logic                       clipped;
	} filt_result_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [biq_pkg::CFG_IDX_BITS-1:0] cfg_index;
	logic [CFG_W-1:0]   cfg_wdata;

	biq_in_if #(.SAMPLE_BITS(SAMPLE_W)) sample_chan ();
	biq_out_if #(.SAMPLE_BITS(SAMPLE_W)) result_chan ();

	biquad_iir_filter_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.sample_chan (sample_chan),
		.result_chan (result_chan)
	);

	logic signed [COEF_W-1:0] coefs [5];
	logic signed [INIT_W-1:0] init_first, init_second;
	longint                   delay_one, delay_two;
	filt_result_t             pending_outputs [$];
	int                       error_count;
	bit                       tx_idle_on;
	bit                       rx_idle_on;
	int                       rx_hold_cycles;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	initial begin
		#5ms;
		$display("testbench: done, errors");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		error_count++;
	endtask

	function automatic longint clamp_state(input longint v);
		if (v > STATE_MAX)
			return STATE_MAX;
		if (v < STATE_MIN)
			return STATE_MIN;
		return v;
	endfunction

	function automatic longint mul_state(input logic signed [COEF_W-1:0] c, input longint v);
		return clamp_state(longint'(c) * v);
	endfunction

	function automatic void mirror_reg_write(input logic [biq_pkg::CFG_IDX_BITS-1:0] idx,
			input logic [CFG_W-1:0] data);
		unique case (idx)
			biq_pkg::REG_COEF_B0: coefs[0] = data[COEF_W-1:0];
			biq_pkg::REG_COEF_B1: coefs[1] = data[COEF_W-1:0];
			biq_pkg::REG_COEF_B2: coefs[2] = data[COEF_W-1:0];
			biq_pkg::REG_COEF_A1: coefs[3] = data[COEF_W-1:0];
			biq_pkg::REG_COEF_A2: coefs[4] = data[COEF_W-1:0];
			biq_pkg::REG_INIT_FIRST: init_first = data[INIT_W-1:0];
			biq_pkg::REG_INIT_SECOND: init_second = data[INIT_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic filt_result_t biquad_predict(input logic signed [SAMPLE_W-1:0] x_in,
			input logic first);
		filt_result_t r;
		longint x, acc, q, y, s1;
		x = longint'(x_in);
		if (first) begin
			delay_one = clamp_state(longint'(init_first) * (64'sd1 <<< FRAC));
			delay_two = clamp_state(longint'(init_second) * (64'sd1 <<< FRAC));
		end
		acc = clamp_state(mul_state(coefs[0], x) + delay_one);
		acc = acc + (64'sd1 <<< (FRAC - 1));
		q = acc >>> FRAC;
		r.clipped = 1'b0;
		if (q > 32767) begin
			y = 32767;
			r.clipped = 1'b1;
		end else if (q < -32768) begin
			y = -32768;
			r.clipped = 1'b1;
		end else begin
			y = q;
		end
		s1 = clamp_state(mul_state(coefs[1], x) - mul_state(coefs[3], y));
		s1 = clamp_state(s1 + delay_two);
		delay_two = clamp_state(mul_state(coefs[2], x) - mul_state(coefs[4], y));
		delay_one = s1;
		r.sample_out = y[SAMPLE_W-1:0];
		return r;
	endfunction

	task automatic write_reg(input logic [biq_pkg::CFG_IDX_BITS-1:0] idx,
			input logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = data;
		@(negedge clk);
		cfg_we = 1'b0;
		mirror_reg_write(idx, data);
	endtask

	task automatic write_all_regs(input logic [CFG_W-1:0] b0, input logic [CFG_W-1:0] b1,
			input logic [CFG_W-1:0] b2, input logic [CFG_W-1:0] a1,
			input logic [CFG_W-1:0] a2, input logic [CFG_W-1:0] i1,
			input logic [CFG_W-1:0] i2);
		write_reg(biq_pkg::REG_COEF_B0, b0);
		write_reg(biq_pkg::REG_COEF_B1, b1);
		write_reg(biq_pkg::REG_COEF_B2, b2);
		write_reg(biq_pkg::REG_COEF_A1, a1);
		write_reg(biq_pkg::REG_COEF_A2, a2);
		write_reg(biq_pkg::REG_INIT_FIRST, i1);
		write_reg(biq_pkg::REG_INIT_SECOND, i2);
	endtask

	task automatic send_sample(input logic signed [SAMPLE_W-1:0] x, input logic first);
		@(negedge clk);
		if (tx_idle_on) begin
			while ($urandom_range(0, 99) < 33) begin
				sample_chan.valid = 1'b0;
				@(negedge clk);
			end
		end
		sample_chan.valid = 1'b1;
		sample_chan.sample_in = x;
		sample_chan.first_sample = first;
		@(posedge clk);
		while (!sample_chan.ready)
			@(posedge clk);
		pending_outputs.push_back(biquad_predict(x, first));
	endtask

	// Wait until every request has produced its result and the sequencer is idle.
	task automatic settle();
		@(negedge clk);
		sample_chan.valid = 1'b0;
		while (pending_outputs.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic check_result(input logic signed [SAMPLE_W-1:0] y, input logic clip);
		filt_result_t e;
		if (pending_outputs.size() == 0) begin
			report_mismatch($sformatf("unexpected result sample_out=%0d clipped=%0b", y, clip));
		end else begin
			e = pending_outputs.pop_front();
			if (y !== e.sample_out)
				report_mismatch($sformatf("sample_out %0d, expected %0d", y, e.sample_out));
			if (clip !== e.clipped)
				report_mismatch($sformatf("clipped %0b, expected %0b", clip, e.clipped));
		end
	endtask

	initial begin
		result_chan.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_cycles > 0) begin
				rx_hold_cycles--;
				result_chan.ready = 1'b0;
			end else begin
				result_chan.ready = !rx_idle_on || ($urandom_range(0, 99) >= 33);
			end
			@(posedge clk);
			if (result_chan.valid && result_chan.ready)
				check_result(result_chan.sample_out, result_chan.clipped);
		end
	end

	function automatic logic signed [SAMPLE_W-1:0] random_sample();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return SAMPLE_W'($urandom_range(0, 65535));
		if (pick < 85)
			return SAMPLE_W'($urandom_range(0, 511) - 256);
		unique case ($urandom_range(0, 3))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'sh0001;
			default: return 16'shFFFF;
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] rand_range(input int lo, input int hi);
		return CFG_W'($urandom_range(0, hi - lo) + lo);
	endfunction

	// Without any first mark the states are zero and the reset gain is one.
	task automatic test_reset_defaults();
		send_sample(16'sh7FFF, 1'b0);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh0000, 1'b0);
		send_sample(16'sh0001, 1'b0);
		send_sample(16'shFFFF, 1'b0);
	endtask

	// Extreme coefficients, bits above the init width and a write to an unused index.
	task automatic test_register_extremes();
		settle();
		write_all_regs(18'h20000, 18'h1FFFF, 18'h3FFFF, 18'h04000, 18'h3C000,
			18'h30000, 18'h2FFFF);
		write_reg(CFG_IDX_UNUSED, 18'h3FFFF);
		send_sample(16'sh7FFF, 1'b1);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh0000, 1'b0);
		send_sample(16'sh3039, 1'b0);
		send_sample(16'shFFFF, 1'b1);
		send_sample(16'sh0001, 1'b0);
	endtask

	// Strong positive feedback drives the wide states into saturation.
	task automatic test_state_saturation();
		settle();
		write_all_regs(18'h1FFFF, 18'h1FFFF, 18'h20000, 18'h20000, 18'h1FFFF,
			18'h00000, 18'h00000);
		send_sample(16'sh7FFF, 1'b1);
		send_sample(16'sh7FFF, 1'b0);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh0000, 1'b0);
		send_sample(16'sh0000, 1'b0);
	endtask

	// A gain of one half puts odd samples exactly halfway between two outputs.
	task automatic test_rounding();
		settle();
		write_all_regs(18'h02000, 18'h00000, 18'h00000, 18'h00000, 18'h00000,
			18'h00000, 18'h00000);
		send_sample(16'sh0001, 1'b1);
		send_sample(16'shFFFF, 1'b0);
		send_sample(16'sh0003, 1'b0);
		send_sample(16'shFFFD, 1'b0);
	endtask

	task automatic test_random_records();
		int remaining, rec_len;
		for (int phase = 0; phase < 10; phase++) begin
			settle();
			unique case (phase)
				1: write_all_regs(18'h20000, 18'h20000, 18'h20000, 18'h20000, 18'h20000,
						18'h10000, 18'h10000);
				2: write_all_regs(18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF,
						18'h0FFFF, 18'h0FFFF);
				5, 8: write_all_regs(rand_range(0, 262143), rand_range(0, 262143),
						rand_range(0, 262143), rand_range(0, 262143),
						rand_range(0, 262143), rand_range(0, 262143),
						rand_range(0, 262143));
				default: write_all_regs(rand_range(-16384, 16384), rand_range(-8192, 8192),
						rand_range(-8192, 8192), rand_range(-24000, 24000),
						rand_range(0, 12000), rand_range(-65536, 65535),
						rand_range(-65536, 65535));
			endcase
			write_reg(CFG_IDX_UNUSED, rand_range(0, 262143));
			tx_idle_on = (phase != 3);
			rx_idle_on = (phase != 3);
			remaining = 100;
			while (remaining > 0) begin
				rec_len = $urandom_range(1, 40);
				for (int k = 0; k < rec_len && remaining > 0; k++) begin
					send_sample(random_sample(), (k == 0) || ($urandom_range(0, 99) < 3));
					remaining--;
				end
			end
		end
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	// The receiver holds off long enough for the block to fill and refuse requests.
	task automatic test_output_stall();
		settle();
		write_all_regs(18'h04000, 18'h02000, 18'h01000, 18'h3E000, 18'h00800,
			18'h00100, 18'h1FF00);
		tx_idle_on = 1'b0;
		rx_hold_cycles = 300;
		for (int k = 0; k < 20; k++)
			send_sample(random_sample(), k == 0);
		tx_idle_on = 1'b1;
	endtask

	task automatic finish_run();
		int waited;
		@(negedge clk);
		sample_chan.valid = 1'b0;
		waited = 0;
		while (pending_outputs.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);
		if (pending_outputs.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_outputs.size()));
		if (error_count == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = biq_pkg::REG_COEF_B0;
		cfg_wdata = '0;
		sample_chan.valid = 1'b0;
		sample_chan.sample_in = '0;
		sample_chan.first_sample = 1'b0;
		coefs[0] = 18'sd16384;
		for (int k = 1; k < 5; k++)
			coefs[k] = '0;
		init_first = '0;
		init_second = '0;
		delay_one = 0;
		delay_two = 0;
		error_count = 0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		rx_hold_cycles = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_register_extremes();
		test_state_saturation();
		test_rounding();
		test_random_records();
		test_output_stall();
		finish_run();
	end
endmodule
